// ===== hw/rtl/rsd_pkg.sv =====
// ----------------------------------------------------------------------------
// Ring stage task dispatcher package
// Item types, task kind codes and sequencer states shared by the dispatcher.
// ----------------------------------------------------------------------------
package rsd_pkg;

    localparam int LIFE_W  = 6;
    localparam int ENTRY_W = LIFE_W + 1;

    localparam logic KIND_ENQ  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic TASK_PUSH = 1'b0;
    localparam logic TASK_POP  = 1'b1;

    typedef enum logic [2:0] {
        K_PUSH  = 3'd0,
        K_POP   = 3'd1,
        K_WB    = 3'd2,
        K_LOCK  = 3'd3,
        K_EMPTY = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_TICK,
        ST_ENQ,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              kind;
        logic [2:0]        unit;
        logic              task_kind;
        logic [LIFE_W-1:0] lifetime;
    } t_in;

    typedef struct packed {
        logic        accepted;
        logic [3:0]  busy_units;
        logic [3:0]  finished_tasks;
        logic [31:0] busy_total;
        logic [31:0] tick_total;
    } t_out;

endpackage

// ===== hw/rtl/rsd_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/ring_stage_task_dispatcher_top.sv =====
// ----------------------------------------------------------------------------
// Ring stage task dispatcher
// Ring of units with one task queue each; ticks move, count and dispatch
// tasks by rotating the ring past one shared update step.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                  Payload
//  in       input      i_in_valid / o_in_ready    i_in_data  (rsd_pkg::t_in)
//  out      output     o_out_valid / i_out_ready  o_out_data (rsd_pkg::t_out)
//
//  A tick item goes through ST_PREP then ST_TICK, an enqueue item through
//  ST_ENQ, then ST_DONE; the ring rotates one unit a cycle past the update.
//  ST_DONE waits while an earlier result has not yet been taken.
//  Synchronous active-low reset empties every unit and queue and clears sums.
//  Input is taken only in the idle state; a result waits in the output
//  register and the next item may be accepted while it waits.
// ----------------------------------------------------------------------------
module ring_stage_task_dispatcher_top #(
    parameter int UNITS       = 8,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  rsd_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output rsd_pkg::t_out o_out_data
);

    import rsd_pkg::*;

    localparam int IW = $clog2(UNITS);
    localparam int HW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int PW = $clog2(2 * QUEUE_DEPTH);
    localparam int CW = $clog2(UNITS + 1);
    localparam int MD = UNITS * QUEUE_DEPTH;
    localparam int AW = $clog2(MD);

    t_state            r_state, n_state;
    t_kind             r_kind [UNITS];
    t_kind             n_kind [UNITS];
    logic [LIFE_W-1:0] r_life [UNITS];
    logic [LIFE_W-1:0] n_life [UNITS];
    logic [HW-1:0]     r_head [UNITS];
    logic [HW-1:0]     n_head [UNITS];
    logic [FW-1:0]     r_fill [UNITS];
    logic [FW-1:0]     n_fill [UNITS];
    logic [IW-1:0]     r_idx, n_idx;
    logic [AW-1:0]     r_base, n_base;
    t_kind             r_pk, n_pk;
    logic [LIFE_W-1:0] r_pl, n_pl;
    logic [LIFE_W-1:0] r_last_life, n_last_life;
    logic              r_lock_last, n_lock_last;
    logic [CW-1:0]     r_nb, n_nb;
    logic [CW-1:0]     r_nf, n_nf;
    logic [31:0]       r_busy_sum, n_busy_sum;
    logic [31:0]       r_tick_sum, n_tick_sum;
    t_in               r_item, n_item;
    logic              r_acc, n_acc;
    t_out              r_out, n_out;
    logic              r_out_valid, n_out_valid;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [ENTRY_W-1:0] mem_rdata;

    t_kind             cur_k;
    logic [LIFE_W-1:0] cur_l;
    logic [HW-1:0]     cur_h;
    logic [FW-1:0]     cur_f;
    logic [LIFE_W-1:0] prev_life;
    logic              take;
    logic              lock_prev;
    logic              last_step;
    logic [PW-1:0]     enq_sum;
    logic [HW-1:0]     enq_pos;
    logic [31:0]       nb_wide;
    logic [31:0]       nf_wide;

    rsd_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(MD)
    ) u_queue_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_busy_sum  <= '0;
            r_tick_sum  <= '0;
            for (int p = 0; p < UNITS; p++) begin
                r_kind[p] <= K_EMPTY;
                r_life[p] <= '0;
                r_head[p] <= '0;
                r_fill[p] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_busy_sum  <= n_busy_sum;
            r_tick_sum  <= n_tick_sum;
            r_kind      <= n_kind;
            r_life      <= n_life;
            r_head      <= n_head;
            r_fill      <= n_fill;
        end
        r_idx       <= n_idx;
        r_base      <= n_base;
        r_pk        <= n_pk;
        r_pl        <= n_pl;
        r_last_life <= n_last_life;
        r_lock_last <= n_lock_last;
        r_nb        <= n_nb;
        r_nf        <= n_nf;
        r_item      <= n_item;
        r_acc       <= n_acc;
        r_out       <= n_out;
    end

    assign last_step = (r_idx == IW'(UNITS - 1));
    assign enq_sum   = PW'(r_head[0]) + PW'(r_fill[0]);
    assign enq_pos   = (enq_sum >= PW'(QUEUE_DEPTH)) ?
                       HW'(enq_sum - PW'(QUEUE_DEPTH)) : HW'(enq_sum);
    assign nb_wide   = 32'(r_nb);
    assign nf_wide   = 32'(r_nf);

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_life      = r_life;
        n_head      = r_head;
        n_fill      = r_fill;
        n_idx       = r_idx;
        n_base      = r_base;
        n_pk        = r_pk;
        n_pl        = r_pl;
        n_last_life = r_last_life;
        n_lock_last = r_lock_last;
        n_nb        = r_nb;
        n_nf        = r_nf;
        n_busy_sum  = r_busy_sum;
        n_tick_sum  = r_tick_sum;
        n_item      = r_item;
        n_acc       = r_acc;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        mem_we    = 1'b0;
        mem_waddr = r_base + AW'(enq_pos);
        mem_wdata = {r_item.task_kind, r_item.lifetime};
        mem_raddr = r_base + AW'(r_head[0]);

        cur_k     = r_kind[0];
        cur_l     = r_life[0];
        cur_h     = r_head[0];
        cur_f     = r_fill[0];
        prev_life = r_last_life;
        take      = 1'b0;
        lock_prev = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_data;
                    n_idx   = '0;
                    n_base  = '0;
                    n_acc   = 1'b0;
                    n_nb    = '0;
                    n_nf    = '0;
                    n_state = (i_in_data.kind == KIND_TICK) ? ST_PREP : ST_ENQ;
                end
            end
            ST_PREP: begin
                mem_raddr   = AW'(r_head[0]);
                n_pk        = r_kind[UNITS-1];
                n_pl        = r_life[UNITS-1];
                n_lock_last = 1'b0;
                if (r_kind[UNITS-1] == K_POP) begin
                    n_last_life = r_life[UNITS-1];
                end else if (r_life[UNITS-2] > LIFE_W'(1)) begin
                    n_last_life = r_life[UNITS-2] - LIFE_W'(1);
                end else begin
                    n_last_life = '0;
                end
                n_state = ST_TICK;
            end
            ST_TICK: begin
                if (r_kind[0] == K_PUSH || r_kind[0] == K_POP || r_kind[0] == K_WB) begin
                    n_nb = r_nb + CW'(1);
                end
                if (r_life[0] == LIFE_W'(1) && (r_kind[0] == K_PUSH || r_kind[0] == K_WB)) begin
                    n_nf = r_nf + CW'(1);
                end
                n_pk = r_kind[0];
                n_pl = r_life[0];

                if (r_kind[0] == K_POP) begin
                    cur_k = K_WB;
                    cur_l = r_life[0];
                end else if (r_pl > LIFE_W'(1)) begin
                    cur_k = r_pk;
                    cur_l = r_pl - LIFE_W'(1);
                end else begin
                    cur_k = K_EMPTY;
                    cur_l = '0;
                end
                if (last_step && r_lock_last) begin
                    cur_k = K_LOCK;
                    cur_l = LIFE_W'(1);
                end

                prev_life = (r_idx == '0) ? r_last_life : r_life[UNITS-1];
                if (cur_k == K_EMPTY && r_fill[0] != '0) begin
                    take = (mem_rdata[ENTRY_W-1] == TASK_PUSH) || (prev_life <= LIFE_W'(1));
                    if (take) begin
                        cur_k = (mem_rdata[ENTRY_W-1] == TASK_POP) ? K_POP : K_PUSH;
                        cur_l = mem_rdata[LIFE_W-1:0];
                        cur_h = (r_head[0] == HW'(QUEUE_DEPTH - 1)) ? '0 : r_head[0] + HW'(1);
                        cur_f = r_fill[0] - FW'(1);
                        lock_prev = (mem_rdata[ENTRY_W-1] == TASK_POP);
                    end
                end
                if (lock_prev && r_idx == '0) begin
                    n_lock_last = 1'b1;
                end

                for (int p = 0; p < UNITS - 1; p++) begin
                    n_kind[p] = r_kind[p+1];
                    n_life[p] = r_life[p+1];
                    n_head[p] = r_head[p+1];
                    n_fill[p] = r_fill[p+1];
                end
                if (lock_prev && r_idx != '0) begin
                    n_kind[UNITS-2] = K_LOCK;
                    n_life[UNITS-2] = LIFE_W'(1);
                end
                n_kind[UNITS-1] = cur_k;
                n_life[UNITS-1] = cur_l;
                n_head[UNITS-1] = cur_h;
                n_fill[UNITS-1] = cur_f;

                mem_raddr = r_base + AW'(QUEUE_DEPTH) + AW'(r_head[1]);
                n_base    = r_base + AW'(QUEUE_DEPTH);
                n_idx     = r_idx + IW'(1);
                if (last_step) begin
                    n_busy_sum = r_busy_sum + 32'(n_nb);
                    n_tick_sum = r_tick_sum + 32'd1;
                    n_state    = ST_DONE;
                end
            end
            ST_ENQ: begin
                if (32'(r_item.unit) == 32'(r_idx) && r_fill[0] != FW'(QUEUE_DEPTH)) begin
                    mem_we = 1'b1;
                    n_acc  = 1'b1;
                    cur_f  = r_fill[0] + FW'(1);
                end
                for (int p = 0; p < UNITS - 1; p++) begin
                    n_kind[p] = r_kind[p+1];
                    n_life[p] = r_life[p+1];
                    n_head[p] = r_head[p+1];
                    n_fill[p] = r_fill[p+1];
                end
                n_kind[UNITS-1] = r_kind[0];
                n_life[UNITS-1] = r_life[0];
                n_head[UNITS-1] = r_head[0];
                n_fill[UNITS-1] = cur_f;

                n_base = r_base + AW'(QUEUE_DEPTH);
                n_idx  = r_idx + IW'(1);
                if (last_step) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.accepted       = r_acc;
                    n_out.busy_units     = (nb_wide > 32'd15) ? 4'd15 : nb_wide[3:0];
                    n_out.finished_tasks = (nf_wide > 32'd15) ? 4'd15 : nf_wide[3:0];
                    n_out.busy_total     = r_busy_sum;
                    n_out.tick_total     = r_tick_sum;
                    n_out_valid          = 1'b1;
                    n_state              = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
